FILE: rtl/hqt_pkg.sv
package hqt_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int ADDR_W = $clog2(NUM_ENTRIES);
	localparam int IDX_W = 6;
	localparam int PAGE_W = 20;
	localparam int FUNC_W = 3;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [PAGE_W-1:0] TOTAL_RESET = PAGE_W'(4096);
	localparam logic [IDX_W-1:0] CHILD_MAX = '1;
	localparam logic REG_ROOT_LIMIT = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_QUERY = 3'd0,
		FUNC_SPLIT = 3'd1,
		FUNC_ALLOC = 3'd2,
		FUNC_FREE  = 3'd3,
		FUNC_INIT  = 3'd4
	} func_t;

	typedef struct packed {
		logic [PAGE_W-1:0] quota;
		logic [PAGE_W-1:0] usage;
		logic [IDX_W-1:0]  parent;
		logic [IDX_W-1:0]  children;
	} hqt_entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		hqt_entry_t        wr_data;
		logic              wr_mark;
		logic              init_en;
		logic [PAGE_W-1:0] root_quota;
		logic [ADDR_W-1:0] look_id;
		logic [ADDR_W-1:0] look_child;
	} hqt_tbl_cmd_t;

	typedef struct packed {
		hqt_entry_t entry;
		logic       id_used;
		logic       child_used;
	} hqt_tbl_stat_t;

endpackage

FILE: rtl/hqt_req_if.sv
interface hqt_req_if import hqt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  id;
	logic [IDX_W-1:0]  child;
	logic [PAGE_W-1:0] amount;

	modport source (output valid, func, id, child, amount, input ready);
	modport sink (input valid, func, id, child, amount, output ready);
endinterface

FILE: rtl/hqt_rsp_if.sv
interface hqt_rsp_if import hqt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic              can_consume;
	logic [IDX_W-1:0]  parent_id;
	logic [IDX_W-1:0]  child_count;
	logic [PAGE_W-1:0] quota_pages;
	logic [PAGE_W-1:0] usage_pages;

	modport source (output valid, status, can_consume, parent_id, child_count,
		quota_pages, usage_pages, input ready);
	modport sink (input valid, status, can_consume, parent_id, child_count,
		quota_pages, usage_pages, output ready);
endinterface

FILE: rtl/hqt_table.sv
module hqt_table import hqt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  hqt_tbl_cmd_t  cmd,
	output hqt_tbl_stat_t stat
);

	hqt_entry_t              mem [NUM_ENTRIES];
	hqt_entry_t              rd_q;
	logic                    rd_zero_q;
	logic                    fresh_q;
	logic [PAGE_W-1:0]       root_quota_q;
	logic [NUM_ENTRIES-1:0]  used_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= NUM_ENTRIES'(1);
			fresh_q      <= 1'b1;
			root_quota_q <= TOTAL_RESET;
			rd_zero_q    <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_zero_q <= (cmd.rd_addr == '0);
			end
			if (cmd.init_en) begin
				used_q       <= NUM_ENTRIES'(1);
				fresh_q      <= 1'b1;
				root_quota_q <= cmd.root_quota;
			end else if (cmd.wr_en) begin
				if (cmd.wr_mark) begin
					used_q[cmd.wr_addr] <= 1'b1;
				end
				if (cmd.wr_addr == '0) begin
					fresh_q <= 1'b0;
				end
			end
		end
	end

	// root reads as its init value until first written
	always_comb begin
		stat.entry = rd_q;
		if (rd_zero_q && fresh_q) begin
			stat.entry.quota    = root_quota_q;
			stat.entry.usage    = '0;
			stat.entry.parent   = '0;
			stat.entry.children = '0;
		end
		stat.id_used    = used_q[cmd.look_id];
		stat.child_used = used_q[cmd.look_child];
	end

endmodule

FILE: rtl/hierarchical_quota_table.sv
// channel  direction  handshake      payload
// req      in         valid/ready    func, id, child, amount
// rsp      out        valid/ready    status, can_consume, parent_id, child_count,
//                                    quota_pages, usage_pages
// cfg      in         apb, pready=1  root page limit at byte address 0
//
// the accept cycle reads the entry memory, S_EXEC updates it and loads the result
// register; a split that succeeds then passes through S_CHILD, as the child entry
// needs a second write through the single memory write port.
// after reset the table is usable at once: used marks live in flip-flops.
// a request waits in the update cycle while the result register is still full.
module hierarchical_quota_table import hqt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	hqt_req_if.sink           req,
	hqt_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_CHILD
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  id_q;
	logic [IDX_W-1:0]  child_q;
	logic [PAGE_W-1:0] amount_q;
	logic [PAGE_W-1:0] root_limit_q;

	logic              rsp_valid_q;
	logic              status_q;
	logic              can_consume_q;
	logic [IDX_W-1:0]  parent_id_q;
	logic [IDX_W-1:0]  child_count_q;
	logic [PAGE_W-1:0] quota_pages_q;
	logic [PAGE_W-1:0] usage_pages_q;

	hqt_tbl_cmd_t      cmd;
	hqt_tbl_stat_t     stat;

	logic              accept;
	logic              go;
	logic              id_in;
	logic              child_in;
	logic              live;
	logic              live_after;
	logic              ok;
	logic              upd;
	logic              room_ok;
	logic [PAGE_W-1:0] room;
	logic [PAGE_W-1:0] room_after;
	hqt_entry_t        ne;

	hqt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign go        = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	// update of entry id
	always_comb begin
		id_in    = 32'(id_q) < NUM_ENTRIES;
		child_in = 32'(child_q) < NUM_ENTRIES;
		live     = id_in && stat.id_used;
		room     = (stat.entry.usage > stat.entry.quota) ? '0
			: stat.entry.quota - stat.entry.usage;
		room_ok  = room >= amount_q;
		ne         = stat.entry;
		ok         = 1'b0;
		upd        = 1'b0;
		live_after = live;
		case (func_t'(func_q))
			FUNC_QUERY: begin
				ok = 1'b1;
			end
			FUNC_SPLIT: begin
				ok       = live && child_in && !stat.child_used && room_ok;
				upd      = ok;
				ne.usage = stat.entry.usage + amount_q;
				if (stat.entry.children < CHILD_MAX) begin
					ne.children = stat.entry.children + IDX_W'(1);
				end
			end
			FUNC_ALLOC: begin
				ok       = live && room_ok;
				upd      = ok;
				ne.usage = stat.entry.usage + amount_q;
			end
			FUNC_FREE: begin
				ok       = live && (stat.entry.usage >= amount_q);
				upd      = ok;
				ne.usage = stat.entry.usage - amount_q;
			end
			FUNC_INIT: begin
				ok          = 1'b1;
				ne.quota    = root_limit_q;
				ne.usage    = '0;
				ne.parent   = '0;
				ne.children = '0;
				live_after  = (id_q == '0);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (!upd) begin
			if (func_t'(func_q) != FUNC_INIT) begin
				ne = stat.entry;
			end
		end
		room_after = (ne.usage > ne.quota) ? '0 : ne.quota - ne.usage;
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_en      = accept;
		cmd.rd_addr    = ADDR_W'(req.id);
		cmd.look_id    = ADDR_W'(id_q);
		cmd.look_child = ADDR_W'(child_q);
		cmd.root_quota = root_limit_q;
		cmd.init_en    = go && (func_t'(func_q) == FUNC_INIT);
		if (state_q == S_CHILD) begin
			cmd.wr_en            = 1'b1;
			cmd.wr_addr          = ADDR_W'(child_q);
			cmd.wr_mark          = 1'b1;
			cmd.wr_data.quota    = amount_q;
			cmd.wr_data.usage    = '0;
			cmd.wr_data.parent   = id_q;
			cmd.wr_data.children = '0;
		end else begin
			cmd.wr_en   = go && upd;
			cmd.wr_addr = ADDR_W'(id_q);
			cmd.wr_data = ne;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			id_q     <= req.id;
			child_q  <= req.child;
			amount_q <= req.amount;
		end
		if (go) begin
			status_q      <= !ok;
			can_consume_q <= live_after && (room_after >= amount_q);
			parent_id_q   <= live_after ? ne.parent : '0;
			child_count_q <= live_after ? ne.children : '0;
			quota_pages_q <= live_after ? ne.quota : '0;
			usage_pages_q <= live_after ? ne.usage : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			root_limit_q <= TOTAL_RESET;
		end else begin
			if (psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_ROOT_LIMIT)) begin
				root_limit_q <= pwdata[PAGE_W-1:0];
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= (upd && (func_t'(func_q) == FUNC_SPLIT)) ? S_CHILD : S_IDLE;
					end
				end
				S_CHILD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[CFG_AW-1:2] == REG_ROOT_LIMIT)
		? CFG_DW'(root_limit_q) : '0;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.can_consume = can_consume_q;
	assign rsp.parent_id   = parent_id_q;
	assign rsp.child_count = child_count_q;
	assign rsp.quota_pages = quota_pages_q;
	assign rsp.usage_pages = usage_pages_q;

endmodule
